@@ rtl/core/hrhp_pkg.sv @@
package hrhp_pkg;

  localparam int unsigned OFFSET_BITS = 16;
  localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = {OFFSET_BITS{1'b1}};
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam logic [7:0] HEADER_MAX = 8'hFF;

  localparam logic [7:0] CHAR_SP      = 8'h20;
  localparam logic [7:0] CHAR_HTAB    = 8'h09;
  localparam logic [7:0] CHAR_CR      = 8'h0D;
  localparam logic [7:0] CHAR_LF      = 8'h0A;
  localparam logic [7:0] CHAR_SLASH   = 8'h2F;
  localparam logic [7:0] CHAR_QUEST   = 8'h3F;
  localparam logic [7:0] CHAR_PERCENT = 8'h25;
  localparam logic [7:0] CHAR_COLON   = 8'h3A;
  localparam logic [7:0] VIS_LOW      = 8'h21;
  localparam logic [7:0] VIS_HIGH     = 8'h7E;

  typedef enum logic [3:0] {
    PH_METHOD_FIRST,
    PH_METHOD,
    PH_TARGET_FIRST,
    PH_PATH,
    PH_QUERY,
    PH_VERSION,
    PH_REQ_CR,
    PH_REQ_LF,
    PH_LINE_START,
    PH_NAME,
    PH_OWS,
    PH_VALUE,
    PH_HDR_LF,
    PH_FINAL_LF,
    PH_DONE,
    PH_REJECT
  } phase_e;

  typedef enum logic [2:0] {
    ROLE_SEP,
    ROLE_METHOD,
    ROLE_TARGET,
    ROLE_VERSION,
    ROLE_NAME,
    ROLE_VALUE_CHAR,
    ROLE_VALUE_WS
  } role_e;

  typedef enum logic [1:0] {
    STATUS_PARSING,
    STATUS_ACCEPTED,
    STATUS_REJECTED
  } status_e;

  // byte plus its start flag and character classes
  typedef struct packed {
    logic [7:0] data_byte;
    logic       start;
    logic       is_tok;
    logic       is_vis;
    logic       is_ws;
    logic       is_hex;
    logic       is_pch;
  } entry_t;

  typedef struct packed {
    logic   push;
    entry_t entry;
  } q_wr_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } q_rd_t;

  function automatic logic [7:0] version_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0: ch = 8'h48;
      3'd1: ch = 8'h54;
      3'd2: ch = 8'h54;
      3'd3: ch = 8'h50;
      3'd4: ch = 8'h2F;
      3'd5: ch = 8'h31;
      3'd6: ch = 8'h2E;
      default: ch = 8'h31;
    endcase
    return ch;
  endfunction

endpackage

@@ rtl/core/hrhp_in_if.sv @@
interface hrhp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_request;

  modport source(output valid, output data_byte, output start_of_request, input ready);
  modport sink(input valid, input data_byte, input start_of_request, output ready);
endinterface

@@ rtl/core/hrhp_out_if.sv @@
interface hrhp_out_if;
  logic                             valid;
  logic                             ready;
  logic [hrhp_pkg::OFFSET_BITS-1:0] byte_offset;
  logic [2:0]                       role;
  logic [1:0]                       status;
  logic [7:0]                       header_index;
  logic [hrhp_pkg::OFFSET_BITS-1:0] value_end;
  logic                             value_end_valid;

  modport source(output valid, output byte_offset, output role, output status,
                 output header_index, output value_end, output value_end_valid,
                 input ready);
  modport sink(input valid, input byte_offset, input role, input status,
               input header_index, input value_end, input value_end_valid,
               output ready);
endinterface

@@ rtl/core/hrhp_front.sv @@
module hrhp_front (
  hrhp_in_if.sink        in_i,
  input  logic           full_i,
  output hrhp_pkg::q_wr_t wr_o
);

  logic [7:0] c;
  logic       vis;
  logic       delim;
  logic       alnum;

  assign c = in_i.data_byte;

  always_comb begin
    vis   = (c >= hrhp_pkg::VIS_LOW) && (c <= hrhp_pkg::VIS_HIGH);
    delim = c inside {8'h22, 8'h28, 8'h29, 8'h2C, 8'h2F, 8'h3A, 8'h3B, 8'h3C, 8'h3D,
                      8'h3E, 8'h3F, 8'h40, 8'h5B, 8'h5C, 8'h5D, 8'h7B, 8'h7D};
    alnum = (c inside {[8'h41:8'h5A]}) || (c inside {[8'h61:8'h7A]})
         || (c inside {[8'h30:8'h39]});

    wr_o.push             = in_i.valid && !full_i;
    wr_o.entry.data_byte  = c;
    wr_o.entry.start      = in_i.start_of_request;
    wr_o.entry.is_vis     = vis;
    wr_o.entry.is_tok     = vis && !delim;
    wr_o.entry.is_ws      = (c == hrhp_pkg::CHAR_SP) || (c == hrhp_pkg::CHAR_HTAB);
    wr_o.entry.is_hex     = (c inside {[8'h30:8'h39]}) || (c inside {[8'h41:8'h46]})
                         || (c inside {[8'h61:8'h66]});
    // pchar or slash
    wr_o.entry.is_pch     = alnum
                         || (c inside {8'h2D, 8'h2E, 8'h5F, 8'h7E, 8'h3A, 8'h40, 8'h2F})
                         || (c inside {8'h21, 8'h24, 8'h26, 8'h27, 8'h28, 8'h29, 8'h2A,
                                       8'h2B, 8'h2C, 8'h3B, 8'h3D});
  end

  assign in_i.ready = !full_i;

endmodule

@@ rtl/core/hrhp_queue.sv @@
module hrhp_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  hrhp_pkg::q_wr_t wr_i,
  input  logic            pop_i,
  output logic            full_o,
  output hrhp_pkg::q_rd_t rd_o
);

  localparam int unsigned PtrBits = hrhp_pkg::QUEUE_PTR_BITS;

  hrhp_pkg::entry_t             mem_q [hrhp_pkg::QUEUE_DEPTH];
  logic [PtrBits-1:0]           wr_ptr_q, wr_ptr_d;
  logic [PtrBits-1:0]           rd_ptr_q, rd_ptr_d;
  logic [PtrBits:0]             count_q, count_d;
  logic                         do_pop;

  assign full_o   = (count_q == (PtrBits+1)'(hrhp_pkg::QUEUE_DEPTH));
  assign do_pop   = pop_i && (count_q != '0);
  assign rd_o.valid = (count_q != '0);
  assign rd_o.entry = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (wr_i.push) begin
      wr_ptr_d = wr_ptr_q + PtrBits'(1);
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + PtrBits'(1);
    end
    count_d = count_q + (PtrBits+1)'(wr_i.push) - (PtrBits+1)'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.push) begin
      mem_q[wr_ptr_q] <= wr_i.entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !wr_i.push)
    else $error("queue written while full");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (PtrBits+1)'(hrhp_pkg::QUEUE_DEPTH))
    else $error("queue count out of range");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_ptr_q - rd_ptr_q) == count_q[PtrBits-1:0])
    else $error("queue pointers disagree with count");

endmodule

@@ rtl/core/hrhp_back.sv @@
module hrhp_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  hrhp_pkg::q_rd_t rd_i,
  output logic            pop_o,
  hrhp_out_if.source      out_o
);

  localparam int unsigned OB = hrhp_pkg::OFFSET_BITS;

  hrhp_pkg::phase_e  phase_q, phase_d;
  logic [2:0]        vpos_q, vpos_d;
  logic [1:0]        hex_q, hex_d;
  logic [OB-1:0]     pos_q, pos_d;
  logic [OB-1:0]     tve_q, tve_d;
  logic [7:0]        hc_q, hc_d;

  logic              out_valid_q;
  logic [OB-1:0]     off_q, off_d;
  hrhp_pkg::role_e   role_q, role_d;
  hrhp_pkg::status_e status_q, status_d;
  logic [7:0]        hidx_q, hidx_d;
  logic [OB-1:0]     vend_q, vend_d;
  logic              vvalid_q, vvalid_d;

  hrhp_pkg::entry_t  e;
  logic [7:0]        c;
  logic              rej;

  assign e     = rd_i.entry;
  assign c     = e.data_byte;
  assign pop_o = rd_i.valid && (!out_valid_q || out_o.ready);

  always_comb begin
    phase_d = phase_q;
    vpos_d  = vpos_q;
    hex_d   = hex_q;
    pos_d   = pos_q;
    tve_d   = tve_q;
    hc_d    = hc_q;
    if (e.start) begin
      phase_d = hrhp_pkg::PH_METHOD_FIRST;
      vpos_d  = '0;
      hex_d   = '0;
      pos_d   = '0;
      tve_d   = '0;
      hc_d    = '0;
    end
    off_d    = pos_d;
    hidx_d   = hc_d;
    role_d   = hrhp_pkg::ROLE_SEP;
    vend_d   = '0;
    vvalid_d = 1'b0;
    rej      = 1'b0;

    if (phase_d != hrhp_pkg::PH_DONE && phase_d != hrhp_pkg::PH_REJECT
        && pos_d == hrhp_pkg::OFFSET_MAX) begin
      rej = 1'b1;
    end else begin
      case (phase_d)
        hrhp_pkg::PH_METHOD_FIRST, hrhp_pkg::PH_METHOD: begin
          if (e.is_tok) begin
            role_d  = hrhp_pkg::ROLE_METHOD;
            phase_d = hrhp_pkg::PH_METHOD;
          end else if (c == hrhp_pkg::CHAR_SP && phase_d == hrhp_pkg::PH_METHOD) begin
            phase_d = hrhp_pkg::PH_TARGET_FIRST;
          end else begin
            rej = 1'b1;
          end
        end
        hrhp_pkg::PH_TARGET_FIRST: begin
          if (c == hrhp_pkg::CHAR_SLASH) begin
            role_d  = hrhp_pkg::ROLE_TARGET;
            phase_d = hrhp_pkg::PH_PATH;
          end else begin
            rej = 1'b1;
          end
        end
        hrhp_pkg::PH_PATH, hrhp_pkg::PH_QUERY: begin
          if (hex_d != 2'd0) begin
            if (e.is_hex) begin
              role_d = hrhp_pkg::ROLE_TARGET;
              hex_d  = hex_d - 2'd1;
            end else begin
              rej = 1'b1;
            end
          end else if (c == hrhp_pkg::CHAR_PERCENT) begin
            role_d = hrhp_pkg::ROLE_TARGET;
            hex_d  = 2'd2;
          end else if (e.is_pch) begin
            role_d = hrhp_pkg::ROLE_TARGET;
          end else if (c == hrhp_pkg::CHAR_QUEST) begin
            role_d  = hrhp_pkg::ROLE_TARGET;
            phase_d = hrhp_pkg::PH_QUERY;
          end else if (c == hrhp_pkg::CHAR_SP) begin
            phase_d = hrhp_pkg::PH_VERSION;
            vpos_d  = '0;
          end else begin
            rej = 1'b1;
          end
        end
        hrhp_pkg::PH_VERSION: begin
          if (c == hrhp_pkg::version_char(vpos_d)) begin
            role_d = hrhp_pkg::ROLE_VERSION;
            if (vpos_d == 3'd7) begin
              vpos_d  = '0;
              phase_d = hrhp_pkg::PH_REQ_CR;
            end else begin
              vpos_d = vpos_d + 3'd1;
            end
          end else begin
            rej = 1'b1;
          end
        end
        hrhp_pkg::PH_REQ_CR: begin
          if (c == hrhp_pkg::CHAR_CR) begin
            phase_d = hrhp_pkg::PH_REQ_LF;
          end else begin
            rej = 1'b1;
          end
        end
        hrhp_pkg::PH_REQ_LF: begin
          if (c == hrhp_pkg::CHAR_LF) begin
            phase_d = hrhp_pkg::PH_LINE_START;
          end else begin
            rej = 1'b1;
          end
        end
        hrhp_pkg::PH_LINE_START: begin
          if (e.is_tok) begin
            role_d  = hrhp_pkg::ROLE_NAME;
            phase_d = hrhp_pkg::PH_NAME;
          end else if (c == hrhp_pkg::CHAR_CR) begin
            phase_d = hrhp_pkg::PH_FINAL_LF;
          end else begin
            rej = 1'b1;
          end
        end
        hrhp_pkg::PH_NAME: begin
          if (e.is_tok) begin
            role_d = hrhp_pkg::ROLE_NAME;
          end else if (c == hrhp_pkg::CHAR_COLON) begin
            phase_d = hrhp_pkg::PH_OWS;
          end else begin
            rej = 1'b1;
          end
        end
        hrhp_pkg::PH_OWS, hrhp_pkg::PH_VALUE: begin
          if (e.is_vis) begin
            role_d  = hrhp_pkg::ROLE_VALUE_CHAR;
            tve_d   = pos_d + OB'(1);
            phase_d = hrhp_pkg::PH_VALUE;
          end else if (e.is_ws) begin
            if (phase_d == hrhp_pkg::PH_VALUE) begin
              role_d = hrhp_pkg::ROLE_VALUE_WS;
            end
          end else if (c == hrhp_pkg::CHAR_CR) begin
            if (phase_d == hrhp_pkg::PH_OWS) begin
              tve_d = pos_d;
            end
            phase_d = hrhp_pkg::PH_HDR_LF;
          end else begin
            rej = 1'b1;
          end
        end
        hrhp_pkg::PH_HDR_LF: begin
          if (c == hrhp_pkg::CHAR_LF) begin
            vvalid_d = 1'b1;
            vend_d   = tve_d;
            if (hc_d != hrhp_pkg::HEADER_MAX) begin
              hc_d = hc_d + 8'd1;
            end
            phase_d = hrhp_pkg::PH_LINE_START;
          end else begin
            rej = 1'b1;
          end
        end
        hrhp_pkg::PH_FINAL_LF: begin
          if (c == hrhp_pkg::CHAR_LF) begin
            phase_d = hrhp_pkg::PH_DONE;
          end else begin
            rej = 1'b1;
          end
        end
        hrhp_pkg::PH_DONE: begin
          phase_d = hrhp_pkg::PH_DONE;
        end
        default: begin
          phase_d = hrhp_pkg::PH_REJECT;
        end
      endcase
    end

    if (rej) begin
      phase_d  = hrhp_pkg::PH_REJECT;
      role_d   = hrhp_pkg::ROLE_SEP;
      vvalid_d = 1'b0;
      vend_d   = '0;
    end
    if (phase_d == hrhp_pkg::PH_DONE) begin
      status_d = hrhp_pkg::STATUS_ACCEPTED;
    end else if (phase_d == hrhp_pkg::PH_REJECT) begin
      status_d = hrhp_pkg::STATUS_REJECTED;
    end else begin
      status_d = hrhp_pkg::STATUS_PARSING;
    end
    if (pos_d != hrhp_pkg::OFFSET_MAX) begin
      pos_d = pos_d + OB'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= hrhp_pkg::PH_METHOD_FIRST;
      vpos_q      <= '0;
      hex_q       <= '0;
      pos_q       <= '0;
      tve_q       <= '0;
      hc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        phase_q <= phase_d;
        vpos_q  <= vpos_d;
        hex_q   <= hex_d;
        pos_q   <= pos_d;
        tve_q   <= tve_d;
        hc_q    <= hc_d;
      end
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      off_q    <= off_d;
      role_q   <= role_d;
      status_q <= status_d;
      hidx_q   <= hidx_d;
      vend_q   <= vend_d;
      vvalid_q <= vvalid_d;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.byte_offset     = off_q;
  assign out_o.role            = role_q;
  assign out_o.status          = status_q;
  assign out_o.header_index    = hidx_q;
  assign out_o.value_end       = vend_q;
  assign out_o.value_end_valid = vvalid_q;

  a_vend_only_parsing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && vvalid_q) |-> (status_q == hrhp_pkg::STATUS_PARSING
                                   && role_q == hrhp_pkg::ROLE_SEP))
    else $error("value end reported outside a header line end");

  a_reject_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q == hrhp_pkg::STATUS_REJECTED)
      |-> (role_q == hrhp_pkg::ROLE_SEP && !vvalid_q && vend_q == '0))
    else $error("rejected byte carries a role or value end");

  a_reject_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && !e.start && phase_q == hrhp_pkg::PH_REJECT)
      |=> (phase_q == hrhp_pkg::PH_REJECT))
    else $error("left rejected phase without a new request");

  a_hold_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=> ($stable(phase_q) && $stable(pos_q)))
    else $error("parser advanced while result stalled");

endmodule

@@ rtl/core/http_request_head_parser_core.sv @@
// Checks an HTTP/1.1 request head one byte per clock while the result side does
// not stall and tags every byte with its role, the parse status, the header line
// number and, on the LF that closes a header line, the end offset of the trimmed
// value. Sustained rate is one byte per cycle without result stalls, set by the
// parser state loop in the back end. A byte is classified combinationally and
// written into the queue when it is accepted; the parser then takes it from the
// queue and writes its result into the output register. A four-entry queue between
// the classifier and the parser absorbs stalls on the result side; in_i.ready drops
// while the queue is full and returns the cycle after the parser takes a byte from
// it. A byte with start_of_request set restarts the parser and is offset zero.
module http_request_head_parser_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  hrhp_in_if.sink    in_i,
  hrhp_out_if.source out_o
);

  hrhp_pkg::q_wr_t wr;
  hrhp_pkg::q_rd_t rd;
  logic            full;
  logic            pop;

  hrhp_front u_front (
    .in_i   (in_i),
    .full_i (full),
    .wr_o   (wr)
  );

  hrhp_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (wr),
    .pop_i  (pop),
    .full_o (full),
    .rd_o   (rd)
  );

  hrhp_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rd_i   (rd),
    .pop_o  (pop),
    .out_o  (out_o)
  );

endmodule

@@ dv/http_request_head_parser_core_test.sv @@
`timescale 1ns / 100ps

module http_request_head_parser_core_test;
  import hrhp_pkg::*;

  localparam int CLK_HALF = 6;
  localparam int RESET_CYCLES = 10;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int TAIL_CYCLES = 20;
  localparam int LONG_HOLD = 300;
  localparam int MAX_WAIT = 5;
  localparam int SATURATING_LINES = 260;
  localparam int RANDOM_BUDGET = 400;
  localparam logic [63:0] PROTO_TEXT = "HTTP/1.1";
  localparam string PATH_POOL =
    "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-._~:@!$&'()*+,;=";
  localparam string HEX_POOL = "0123456789abcdefABCDEF";

  typedef struct packed {
    logic [OFFSET_BITS-1:0] offset;
    role_e                  role;
    status_e                status;
    logic [7:0]             line_idx;
    logic [OFFSET_BITS-1:0] value_stop;
    logic                   value_stop_ok;
  } byte_tag_t;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
  } head_byte_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  hrhp_in_if  req_if ();
  hrhp_out_if res_if ();

  http_request_head_parser_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (res_if)
  );

  always #CLK_HALF clk_i = ~clk_i;

  head_byte_t byte_backlog[$];
  logic [7:0] frame_q[$];
  byte_tag_t  pending_tags[$];
  head_byte_t next_byte;

  int  errors = 0;
  int  cycle_count = 0;
  int  tx_wait = 0;
  int  rx_wait = 0;
  int  hold_left = 0;
  bit  hold_trigger = 1'b0;
  bit  calm_tx = 1'b0;
  bit  calm_rx = 1'b0;

  // parser state
  phase_e                 ph;
  logic [2:0]             ver_pos;
  logic [1:0]             hex_left;
  logic [OFFSET_BITS-1:0] at_offset;
  logic [OFFSET_BITS-1:0] value_stop;
  logic [7:0]             lines_done;

  function automatic void restart_parser();
    ph = PH_METHOD_FIRST;
    ver_pos = '0;
    hex_left = '0;
    at_offset = '0;
    value_stop = '0;
    lines_done = '0;
  endfunction

  function automatic bit is_visible(input logic [7:0] c);
    return c >= VIS_LOW && c <= VIS_HIGH;
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    return c == CHAR_SP || c == CHAR_HTAB;
  endfunction

  function automatic bit is_token(input logic [7:0] c);
    bit delim;
    case (c)
      "\"", "(", ")", ",", "/", ":", ";", "<", "=", ">", "?", "@", "[", "\\", "]",
      "{", "}": delim = 1'b1;
      default: delim = 1'b0;
    endcase
    return is_visible(c) && !delim;
  endfunction

  function automatic bit is_hex_char(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
  endfunction

  function automatic bit is_path_char(input logic [7:0] c);
    if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || (c >= "0" && c <= "9"))
      return 1'b1;
    case (c)
      "-", ".", "_", "~", ":", "@", "!", "$", "&", "'", "(", ")", "*", "+", ",", ";",
      "=": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic void tag_byte(input logic [7:0] c, input logic first);
    byte_tag_t t;
    bit bad;
    if (first) restart_parser();
    t = '0;
    t.offset = at_offset;
    t.line_idx = lines_done;
    t.role = ROLE_SEP;
    bad = 1'b0;
    if (ph != PH_DONE && ph != PH_REJECT && at_offset == OFFSET_MAX) begin
      bad = 1'b1;
    end else begin
      case (ph)
        PH_METHOD_FIRST, PH_METHOD: begin
          if (is_token(c)) begin
            t.role = ROLE_METHOD;
            ph = PH_METHOD;
          end else if (c == CHAR_SP && ph == PH_METHOD) begin
            ph = PH_TARGET_FIRST;
          end else begin
            bad = 1'b1;
          end
        end
        PH_TARGET_FIRST: begin
          if (c == CHAR_SLASH) begin
            t.role = ROLE_TARGET;
            ph = PH_PATH;
          end else begin
            bad = 1'b1;
          end
        end
        PH_PATH, PH_QUERY: begin
          if (hex_left != 0) begin
            if (is_hex_char(c)) begin
              t.role = ROLE_TARGET;
              hex_left--;
            end else begin
              bad = 1'b1;
            end
          end else if (c == CHAR_PERCENT) begin
            t.role = ROLE_TARGET;
            hex_left = 2'd2;
          end else if (is_path_char(c) || c == CHAR_SLASH) begin
            t.role = ROLE_TARGET;
          end else if (c == CHAR_QUEST) begin
            t.role = ROLE_TARGET;
            ph = PH_QUERY;
          end else if (c == CHAR_SP) begin
            ph = PH_VERSION;
            ver_pos = '0;
          end else begin
            bad = 1'b1;
          end
        end
        PH_VERSION: begin
          if (c == PROTO_TEXT[8*(7-ver_pos) +: 8]) begin
            t.role = ROLE_VERSION;
            if (ver_pos == 3'd7) begin
              ver_pos = '0;
              ph = PH_REQ_CR;
            end else begin
              ver_pos++;
            end
          end else begin
            bad = 1'b1;
          end
        end
        PH_REQ_CR: begin
          if (c == CHAR_CR) ph = PH_REQ_LF;
          else bad = 1'b1;
        end
        PH_REQ_LF: begin
          if (c == CHAR_LF) ph = PH_LINE_START;
          else bad = 1'b1;
        end
        PH_LINE_START: begin
          if (is_token(c)) begin
            t.role = ROLE_NAME;
            ph = PH_NAME;
          end else if (c == CHAR_CR) begin
            ph = PH_FINAL_LF;
          end else begin
            bad = 1'b1;
          end
        end
        PH_NAME: begin
          if (is_token(c)) t.role = ROLE_NAME;
          else if (c == CHAR_COLON) ph = PH_OWS;
          else bad = 1'b1;
        end
        PH_OWS, PH_VALUE: begin
          if (is_visible(c)) begin
            t.role = ROLE_VALUE_CHAR;
            value_stop = at_offset + 1'b1;
            ph = PH_VALUE;
          end else if (is_blank(c)) begin
            if (ph == PH_VALUE) t.role = ROLE_VALUE_WS;
          end else if (c == CHAR_CR) begin
            if (ph == PH_OWS) value_stop = at_offset;
            ph = PH_HDR_LF;
          end else begin
            bad = 1'b1;
          end
        end
        PH_HDR_LF: begin
          if (c == CHAR_LF) begin
            t.value_stop_ok = 1'b1;
            t.value_stop = value_stop;
            if (lines_done != HEADER_MAX) lines_done++;
            ph = PH_LINE_START;
          end else begin
            bad = 1'b1;
          end
        end
        PH_FINAL_LF: begin
          if (c == CHAR_LF) ph = PH_DONE;
          else bad = 1'b1;
        end
        PH_DONE: ;
        default: ph = PH_REJECT;
      endcase
    end
    if (bad) begin
      ph = PH_REJECT;
      t.role = ROLE_SEP;
      t.value_stop_ok = 1'b0;
      t.value_stop = '0;
    end
    if (ph == PH_DONE) t.status = STATUS_ACCEPTED;
    else if (ph == PH_REJECT) t.status = STATUS_REJECTED;
    else t.status = STATUS_PARSING;
    if (at_offset != OFFSET_MAX) at_offset++;
    pending_tags.push_back(t);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  function automatic void match_tag();
    byte_tag_t want;
    if (pending_tags.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual offset %0d role %0d status %0d",
               $time, res_if.byte_offset, res_if.role, res_if.status);
      errors++;
    end else begin
      want = pending_tags.pop_front();
      check_field("byte_offset", want.offset, res_if.byte_offset);
      check_field("role", want.role, res_if.role);
      check_field("status", want.status, res_if.status);
      check_field("header_index", want.line_idx, res_if.header_index);
      check_field("value_end", want.value_stop, res_if.value_end);
      check_field("value_end_valid", want.value_stop_ok, res_if.value_end_valid);
    end
  endfunction

  // request side
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.data_byte <= '0;
      req_if.start_of_request <= 1'b0;
      tx_wait = 0;
    end else begin
      if (req_if.valid && req_if.ready) tag_byte(req_if.data_byte, req_if.start_of_request);
      if (!req_if.valid || req_if.ready) begin
        if (tx_wait > 0) begin
          tx_wait--;
          req_if.valid <= 1'b0;
        end else if (byte_backlog.size() != 0) begin
          next_byte = byte_backlog.pop_front();
          req_if.valid <= 1'b1;
          req_if.data_byte <= next_byte.data;
          req_if.start_of_request <= next_byte.first;
          if ($urandom_range(0, 49) == 0) calm_tx = !calm_tx;
          tx_wait = calm_tx ? 0 : $urandom_range(0, MAX_WAIT);
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // result side
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        match_tag();
        if ($urandom_range(0, 49) == 0) calm_rx = !calm_rx;
        rx_wait = calm_rx ? 0 : $urandom_range(0, MAX_WAIT);
      end
      if (hold_trigger) begin
        hold_trigger = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) frame_q.push_back(s[i]);
  endfunction

  function automatic void add_crlf();
    frame_q.push_back(CHAR_CR);
    frame_q.push_back(CHAR_LF);
  endfunction

  function automatic void ship_frame(input bit with_start);
    head_byte_t b;
    for (int i = 0; i < frame_q.size(); i++) begin
      b.data = frame_q[i];
      b.first = with_start && i == 0;
      byte_backlog.push_back(b);
    end
    frame_q.delete();
  endfunction

  function automatic logic [7:0] pick_token_char();
    logic [7:0] c;
    do c = 8'($urandom_range(VIS_LOW, VIS_HIGH)); while (!is_token(c));
    return c;
  endfunction

  function automatic logic [7:0] pick_blank();
    return $urandom_range(0, 1) ? CHAR_SP : CHAR_HTAB;
  endfunction

  function automatic void add_escape();
    frame_q.push_back(CHAR_PERCENT);
    frame_q.push_back(HEX_POOL[$urandom_range(0, HEX_POOL.len() - 1)]);
    frame_q.push_back(HEX_POOL[$urandom_range(0, HEX_POOL.len() - 1)]);
  endfunction

  function automatic void add_path_char();
    frame_q.push_back(PATH_POOL[$urandom_range(0, PATH_POOL.len() - 1)]);
  endfunction

  function automatic void add_request(input int n_lines);
    repeat ($urandom_range(1, 6)) frame_q.push_back(pick_token_char());
    frame_q.push_back(CHAR_SP);
    frame_q.push_back(CHAR_SLASH);
    repeat ($urandom_range(0, 8)) begin
      case ($urandom_range(0, 9))
        0: add_escape();
        1: frame_q.push_back(CHAR_SLASH);
        default: add_path_char();
      endcase
    end
    if ($urandom_range(0, 2) == 0) begin
      frame_q.push_back(CHAR_QUEST);
      repeat ($urandom_range(0, 6)) begin
        case ($urandom_range(0, 7))
          0: add_escape();
          1: frame_q.push_back(CHAR_SLASH);
          2: frame_q.push_back(CHAR_QUEST);
          default: add_path_char();
        endcase
      end
    end
    frame_q.push_back(CHAR_SP);
    add_text("HTTP/1.1");
    add_crlf();
    repeat (n_lines) begin
      repeat ($urandom_range(1, 8)) frame_q.push_back(pick_token_char());
      frame_q.push_back(CHAR_COLON);
      repeat ($urandom_range(0, 2)) frame_q.push_back(pick_blank());
      repeat ($urandom_range(0, 10)) begin
        if ($urandom_range(0, 3) == 0) frame_q.push_back(pick_blank());
        else frame_q.push_back(8'($urandom_range(VIS_LOW, VIS_HIGH)));
      end
      repeat ($urandom_range(0, 2)) frame_q.push_back(pick_blank());
      add_crlf();
    end
    add_crlf();
  endfunction

  function automatic void damage_frame();
    int at;
    at = $urandom_range(0, frame_q.size() - 1);
    case ($urandom_range(0, 3))
      0: frame_q[at] = 8'($urandom_range(0, 255));
      1: frame_q.delete(at);
      2: frame_q.insert(at, 8'($urandom_range(0, 255)));
      default: frame_q = frame_q[0:at];
    endcase
  endfunction

  function automatic void queue_random_traffic(input int budget);
    int used;
    int kind;
    head_byte_t b;
    used = 0;
    while (used < budget) begin
      kind = $urandom_range(0, 19);
      if (kind < 3) begin
        repeat ($urandom_range(1, 6)) begin
          b.data = 8'($urandom_range(0, 255));
          b.first = $urandom_range(0, 3) == 0;
          byte_backlog.push_back(b);
        end
      end else begin
        add_request($urandom_range(0, 4));
        if (kind < 7) damage_frame();
        used += frame_q.size();
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 3)) frame_q.push_back(8'($urandom_range(0, 255)));
        end
        ship_frame($urandom_range(0, 15) != 0);
      end
    end
  endfunction

  task automatic wait_idle();
    while (byte_backlog.size() != 0 || req_if.valid || pending_tags.size() != 0)
      @(negedge clk_i);
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.data_byte = '0;
    req_if.start_of_request = 1'b0;
    res_if.ready = 1'b0;
    restart_parser();
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // first request without a start flag, then a byte after acceptance
    add_text("A / HTTP/1.1");
    add_crlf();
    add_crlf();
    frame_q.push_back(8'hFF);
    ship_frame(1'b0);

    // escapes, query, empty value, leading and trailing whitespace
    add_text("GET /a%2F?q=%7e/? HTTP/1.1");
    add_crlf();
    add_text("Host:");
    add_crlf();
    add_text("X:  v");
    frame_q.push_back(CHAR_HTAB);
    add_text("v ");
    frame_q.push_back(CHAR_HTAB);
    add_crlf();
    add_crlf();
    ship_frame(1'b1);

    // header line without colon, then bytes after rejection
    add_text("A / HTTP/1.1");
    add_crlf();
    add_text("Bad");
    add_crlf();
    add_crlf();
    frame_q.push_back(8'h00);
    ship_frame(1'b1);

    // wrong version digit
    add_text("A /x HTTP/1.0");
    add_crlf();
    ship_frame(1'b1);
    wait_idle();

    // header counter saturation
    add_text("A / HTTP/1.1");
    add_crlf();
    repeat (SATURATING_LINES) begin
      add_text("h:");
      add_crlf();
    end
    add_crlf();
    ship_frame(1'b1);
    wait_idle();

    queue_random_traffic(RANDOM_BUDGET);
    hold_trigger = 1'b1;
    wait_idle();
    queue_random_traffic(RANDOM_BUDGET);
    wait_idle();

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (errors == 0 && pending_tags.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
